// File: src/array_linked_list_engine_core_macros.svh
// Assertion macros used by the linked list engine sequencer.
`ifndef ARRAY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ALLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define ALLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/alle_pkg.sv
// Shared types, codes and widths of the linked list engine.
`timescale 1ns / 1ps

package alle_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int ACTION_W = 2;
	localparam int POS_W    = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_FREE,
		S_WALK,
		S_INS_FIX,
		S_DEL_FIX,
		S_DUMP
	} state_t;

	// One result beat offered by the controller to the output register
	typedef struct packed {
		logic                       valid;
		logic [STATUS_W-1:0]        status;
		logic signed [VALUE_W-1:0]  item_value;
		logic [LEN_W-1:0]           list_length;
		logic                       last;
	} emit_t;

endpackage

// File: src/alle_link_mem.sv
// Next-link store: synchronous memory whose unwritten entries read as the free chain.
`timescale 1ns / 1ps

module alle_link_mem #(
	parameter int SLOTS = alle_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        re,
	input  logic [$clog2(SLOTS)-1:0]    raddr,
	output logic [$clog2(SLOTS+1)-1:0]  rdata,
	input  logic                        we,
	input  logic [$clog2(SLOTS)-1:0]    waddr,
	input  logic [$clog2(SLOTS+1)-1:0]  wdata
);

	localparam int IW = $clog2(SLOTS + 1);
	localparam int AW = $clog2(SLOTS);

	logic [IW-1:0]    mem_q [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [IW-1:0]    rdata_q;
	logic [IW-1:0]    chain_val;

	// Reset value of an entry: node a+1 links to node a+2, the last one to none
	always_comb begin
		if (raddr == AW'(SLOTS - 1)) begin
			chain_val = '0;
		end else begin
			chain_val = IW'(raddr) + IW'(2);
		end
	end

	// Mark entries as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, hold data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= vld_q[raddr] ? mem_q[raddr] : chain_val;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/alle_value_mem.sv
// Node value store: synchronous memory, one write and one read port.
`timescale 1ns / 1ps

module alle_value_mem #(
	parameter int SLOTS = alle_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             re,
	input  logic [$clog2(SLOTS)-1:0]         raddr,
	output logic [alle_pkg::VALUE_W-1:0]     rdata,
	input  logic                             we,
	input  logic [$clog2(SLOTS)-1:0]         waddr,
	input  logic [alle_pkg::VALUE_W-1:0]     wdata
);

	logic [alle_pkg::VALUE_W-1:0] mem_q [SLOTS];
	logic [alle_pkg::VALUE_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, hold data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/alle_ctrl.sv
// Sequencer: list walks, link updates, free list and result beats.
`timescale 1ns / 1ps
`include "array_linked_list_engine_core_macros.svh"

module alle_ctrl #(
	parameter int SLOTS = alle_pkg::SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [alle_pkg::ACTION_W-1:0]       action,
	input  logic [alle_pkg::POS_W-1:0]          position,
	input  logic signed [alle_pkg::VALUE_W-1:0] value,
	output alle_pkg::emit_t                     emit,
	input  logic                                emit_ok,
	output logic                                lk_re,
	output logic [$clog2(SLOTS)-1:0]            lk_raddr,
	input  logic [$clog2(SLOTS+1)-1:0]          lk_rdata,
	output logic                                lk_we,
	output logic [$clog2(SLOTS)-1:0]            lk_waddr,
	output logic [$clog2(SLOTS+1)-1:0]          lk_wdata,
	output logic                                vl_re,
	output logic [$clog2(SLOTS)-1:0]            vl_raddr,
	input  logic [alle_pkg::VALUE_W-1:0]        vl_rdata,
	output logic                                vl_we,
	output logic [$clog2(SLOTS)-1:0]            vl_waddr,
	output logic [alle_pkg::VALUE_W-1:0]        vl_wdata
);

	localparam int IW = $clog2(SLOTS + 1);
	localparam int AW = $clog2(SLOTS);
	localparam int PW = alle_pkg::POS_W;

	alle_pkg::state_t state_q, state_d;

	logic [IW-1:0] head_q,  head_d;
	logic [IW-1:0] free_q,  free_d;
	logic [IW-1:0] count_q, count_d;
	logic [IW-1:0] k_q,     k_d;
	logic [IW-1:0] t_q,     t_d;
	logic [IW-1:0] prev_q,  prev_d;
	logic [IW-1:0] rem_q,   rem_d;
	logic [IW-1:0] nxt_q,   nxt_d;
	logic [IW-1:0] n_q,     n_d;

	logic [alle_pkg::ACTION_W-1:0] act_q, act_d;
	logic [PW-1:0]                 pos_q, pos_d;
	logic [alle_pkg::VALUE_W-1:0]  val_q, val_d;

	logic [PW:0] pos_ext;
	logic [PW:0] cnt_ext;
	logic        store_full;
	logic        ins_bad;
	logic        del_bad;
	logic        dump_last;

	// Admission checks against the current length
	assign pos_ext    = {1'b0, position};
	assign cnt_ext    = (PW + 1)'(count_q);
	assign store_full = (count_q == IW'(SLOTS)) || (free_q == '0);
	assign ins_bad    = (position == '0) || (pos_ext > cnt_ext + (PW + 1)'(1));
	assign del_bad    = (position == '0) || (pos_ext > cnt_ext);
	assign dump_last  = (n_q == count_q - IW'(1));

	// Next state, memory accesses and result beats
	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		free_d  = free_q;
		count_d = count_q;
		k_d     = k_q;
		t_d     = t_q;
		prev_d  = prev_q;
		rem_d   = rem_q;
		nxt_d   = nxt_q;
		n_d     = n_q;
		act_d   = act_q;
		pos_d   = pos_q;
		val_d   = val_q;

		in_ready = (state_q == alle_pkg::S_IDLE) && emit_ok;

		emit             = '0;
		emit.list_length = alle_pkg::LEN_W'(count_q);
		emit.last        = 1'b1;

		lk_re    = 1'b0;
		lk_raddr = '0;
		lk_we    = 1'b0;
		lk_waddr = '0;
		lk_wdata = '0;
		vl_re    = 1'b0;
		vl_raddr = '0;
		vl_we    = 1'b0;
		vl_waddr = '0;
		vl_wdata = '0;

		case (state_q)
			alle_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					act_d = action;
					pos_d = position;
					val_d = value;
					case (action)
						alle_pkg::ACT_INSERT: begin
							if (store_full) begin
								emit.valid  = 1'b1;
								emit.status = alle_pkg::ST_FULL;
							end else if (ins_bad) begin
								emit.valid  = 1'b1;
								emit.status = alle_pkg::ST_RANGE;
							end else begin
								// take the free head, fetch its link
								k_d      = free_q;
								lk_re    = 1'b1;
								lk_raddr = AW'(free_q - IW'(1));
								state_d  = alle_pkg::S_INS_FREE;
							end
						end
						alle_pkg::ACT_DELETE: begin
							if (del_bad) begin
								emit.valid  = 1'b1;
								emit.status = alle_pkg::ST_RANGE;
							end else begin
								// walk from the head to the victim
								t_d      = head_q;
								rem_d    = IW'(position - PW'(1));
								lk_re    = 1'b1;
								lk_raddr = AW'(head_q - IW'(1));
								state_d  = alle_pkg::S_WALK;
							end
						end
						alle_pkg::ACT_DUMP: begin
							if (count_q == '0) begin
								emit.valid  = 1'b1;
								emit.status = alle_pkg::ST_EMPTY;
							end else begin
								n_d      = '0;
								lk_re    = 1'b1;
								lk_raddr = AW'(head_q - IW'(1));
								vl_re    = 1'b1;
								vl_raddr = AW'(head_q - IW'(1));
								state_d  = alle_pkg::S_DUMP;
							end
						end
						default: begin
							// unused code: drop the beat
						end
					endcase
				end
			end

			alle_pkg::S_INS_FREE: begin
				if (pos_q == PW'(1)) begin
					// link in front of the old head
					emit.valid       = 1'b1;
					emit.status      = alle_pkg::ST_OK;
					emit.list_length = alle_pkg::LEN_W'(count_q + IW'(1));
					if (emit_ok) begin
						free_d   = lk_rdata;
						vl_we    = 1'b1;
						vl_waddr = AW'(k_q - IW'(1));
						vl_wdata = val_q;
						lk_we    = 1'b1;
						lk_waddr = AW'(k_q - IW'(1));
						lk_wdata = head_q;
						head_d   = k_q;
						count_d  = count_q + IW'(1);
						state_d  = alle_pkg::S_IDLE;
					end
				end else begin
					// store the value, then walk to the node before the position
					free_d   = lk_rdata;
					vl_we    = 1'b1;
					vl_waddr = AW'(k_q - IW'(1));
					vl_wdata = val_q;
					t_d      = head_q;
					rem_d    = IW'(pos_q - PW'(2));
					lk_re    = 1'b1;
					lk_raddr = AW'(head_q - IW'(1));
					state_d  = alle_pkg::S_WALK;
				end
			end

			alle_pkg::S_WALK: begin
				if (rem_q != '0) begin
					// advance one link
					prev_d   = t_q;
					t_d      = lk_rdata;
					rem_d    = rem_q - IW'(1);
					lk_re    = 1'b1;
					lk_raddr = AW'(lk_rdata - IW'(1));
					state_d  = alle_pkg::S_WALK;
				end else if (act_q == alle_pkg::ACT_INSERT) begin
					// splice the new node after t
					nxt_d    = lk_rdata;
					lk_we    = 1'b1;
					lk_waddr = AW'(t_q - IW'(1));
					lk_wdata = k_q;
					state_d  = alle_pkg::S_INS_FIX;
				end else begin
					// unlink the victim t
					if (pos_q == PW'(1)) begin
						head_d = lk_rdata;
					end else begin
						lk_we    = 1'b1;
						lk_waddr = AW'(prev_q - IW'(1));
						lk_wdata = lk_rdata;
					end
					state_d = alle_pkg::S_DEL_FIX;
				end
			end

			alle_pkg::S_INS_FIX: begin
				emit.valid       = 1'b1;
				emit.status      = alle_pkg::ST_OK;
				emit.list_length = alle_pkg::LEN_W'(count_q + IW'(1));
				if (emit_ok) begin
					lk_we    = 1'b1;
					lk_waddr = AW'(k_q - IW'(1));
					lk_wdata = nxt_q;
					count_d  = count_q + IW'(1);
					state_d  = alle_pkg::S_IDLE;
				end
			end

			alle_pkg::S_DEL_FIX: begin
				emit.valid       = 1'b1;
				emit.status      = alle_pkg::ST_OK;
				emit.list_length = alle_pkg::LEN_W'(count_q - IW'(1));
				if (emit_ok) begin
					// push the victim on the free list
					lk_we    = 1'b1;
					lk_waddr = AW'(t_q - IW'(1));
					lk_wdata = free_q;
					free_d   = t_q;
					count_d  = count_q - IW'(1);
					state_d  = alle_pkg::S_IDLE;
				end
			end

			alle_pkg::S_DUMP: begin
				emit.valid      = 1'b1;
				emit.status     = alle_pkg::ST_OK;
				emit.item_value = vl_rdata;
				emit.last       = dump_last;
				if (emit_ok) begin
					if (dump_last) begin
						state_d = alle_pkg::S_IDLE;
					end else begin
						// fetch the next node
						n_d      = n_q + IW'(1);
						lk_re    = 1'b1;
						lk_raddr = AW'(lk_rdata - IW'(1));
						vl_re    = 1'b1;
						vl_raddr = AW'(lk_rdata - IW'(1));
					end
				end
			end

			default: begin
				state_d = alle_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alle_pkg::S_IDLE;
			head_q  <= '0;
			free_q  <= IW'(1);
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			count_q <= count_d;
		end
	end

	// Working registers of the current action
	always_ff @(posedge clk) begin
		k_q    <= k_d;
		t_q    <= t_d;
		prev_q <= prev_d;
		rem_q  <= rem_d;
		nxt_q  <= nxt_d;
		n_q    <= n_d;
		act_q  <= act_d;
		pos_q  <= pos_d;
		val_q  <= val_d;
	end

	`ALLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= IW'(SLOTS), "list length above store size")
	`ALLE_ASSERT_NOW(a_head_empty, state_q == alle_pkg::S_IDLE, (head_q == '0) == (count_q == '0), "head link disagrees with length")
	`ALLE_ASSERT_NOW(a_free_avail, (state_q == alle_pkg::S_IDLE) && (count_q != IW'(SLOTS)), free_q != '0, "free list empty below full length")
	`ALLE_ASSERT_NOW(a_free_spent, (state_q == alle_pkg::S_IDLE) && (count_q == IW'(SLOTS)), free_q == '0, "free list not empty at full length")
	`ALLE_ASSERT_NEXT(a_stall_hold, emit.valid && !emit_ok && (state_q != alle_pkg::S_IDLE), $stable(state_q) && $stable(count_q), "state moved while result beat stalled")

endmodule

// File: src/array_linked_list_engine_core.sv
// Top level of the linked list engine: memories, sequencer and output register.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_ready  action, position, value
//   out      from block out_valid / out_ready status, item_value, list_length, last
//
// An insert away from the head walks to the node before its position, a delete to its victim;
// a dump yields one beat per node, a rejected action or an empty dump a single beat.
// The walk follows one next link per cycle through the link memory read port.
// Reset is asynchronous: empty list, free list chained through all nodes.
// A stalled output holds the sequencer at its next result beat; a new action is
// taken only when the output register is empty or hands off its beat that cycle.
`timescale 1ns / 1ps

module array_linked_list_engine_core #(
	parameter int SLOTS = alle_pkg::SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [alle_pkg::ACTION_W-1:0]        action,
	input  logic [alle_pkg::POS_W-1:0]           position,
	input  logic signed [alle_pkg::VALUE_W-1:0]  value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [alle_pkg::STATUS_W-1:0]        status,
	output logic signed [alle_pkg::VALUE_W-1:0]  item_value,
	output logic [alle_pkg::LEN_W-1:0]           list_length,
	output logic                                 last
);

	localparam int IW = $clog2(SLOTS + 1);
	localparam int AW = $clog2(SLOTS);

	alle_pkg::emit_t emit;
	logic            emit_ok;

	logic                         lk_re, lk_we;
	logic [AW-1:0]                lk_raddr, lk_waddr;
	logic [IW-1:0]                lk_rdata, lk_wdata;
	logic                         vl_re, vl_we;
	logic [AW-1:0]                vl_raddr, vl_waddr;
	logic [alle_pkg::VALUE_W-1:0] vl_rdata, vl_wdata;

	logic                                out_valid_q;
	logic [alle_pkg::STATUS_W-1:0]       status_q;
	logic signed [alle_pkg::VALUE_W-1:0] item_value_q;
	logic [alle_pkg::LEN_W-1:0]          list_length_q;
	logic                                last_q;

	alle_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.position (position),
		.value    (value),
		.emit     (emit),
		.emit_ok  (emit_ok),
		.lk_re    (lk_re),
		.lk_raddr (lk_raddr),
		.lk_rdata (lk_rdata),
		.lk_we    (lk_we),
		.lk_waddr (lk_waddr),
		.lk_wdata (lk_wdata),
		.vl_re    (vl_re),
		.vl_raddr (vl_raddr),
		.vl_rdata (vl_rdata),
		.vl_we    (vl_we),
		.vl_waddr (vl_waddr),
		.vl_wdata (vl_wdata)
	);

	alle_link_mem #(
		.SLOTS(SLOTS)
	) u_link_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (lk_re),
		.raddr  (lk_raddr),
		.rdata  (lk_rdata),
		.we     (lk_we),
		.waddr  (lk_waddr),
		.wdata  (lk_wdata)
	);

	alle_value_mem #(
		.SLOTS(SLOTS)
	) u_value_mem (
		.clk   (clk),
		.re    (vl_re),
		.raddr (vl_raddr),
		.rdata (vl_rdata),
		.we    (vl_we),
		.waddr (vl_waddr),
		.wdata (vl_wdata)
	);

	// Output register takes a beat when empty or being drained
	assign emit_ok = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ok) begin
			out_valid_q <= emit.valid;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (emit_ok && emit.valid) begin
			status_q      <= emit.status;
			item_value_q  <= emit.item_value;
			list_length_q <= emit.list_length;
			last_q        <= emit.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign item_value  = item_value_q;
	assign list_length = list_length_q;
	assign last        = last_q;

endmodule

// File: bench/array_linked_list_engine_core_test.sv
// Self-checking bench for the linked list engine: directed table, then random traffic.
`timescale 1ns / 1ps

module array_linked_list_engine_core_test;
	import alle_pkg::*;

	localparam int NODES = SLOTS_DEF;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_ACTIONS = 280;
	localparam int MAX_GAP = 18;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] item_value;
		logic [LEN_W-1:0]          list_length;
		logic                      last;
	} list_beat_t;

	typedef struct packed {
		logic [ACTION_W-1:0]       act;
		logic [POS_W-1:0]          pos;
		logic signed [VALUE_W-1:0] val;
		logic                      typed;
		list_beat_t                beat;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [ACTION_W-1:0]       action;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid;
	logic                      out_ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] item_value;
	logic [LEN_W-1:0]          list_length;
	logic                      last;

	// Shadow copy of the node store, links and free list
	logic signed [VALUE_W-1:0] node_val [1:NODES];
	logic [LEN_W-1:0]          node_next [1:NODES];
	logic [LEN_W-1:0]          list_head;
	logic [LEN_W-1:0]          free_head;
	int                        list_count;

	list_beat_t pending_beats[$];
	stim_row_t  directed_rows[$];

	int error_count;
	int beats_checked;
	int beats_out;
	int cycle_count;
	int n_insert, n_delete, n_dump, n_ignored;
	int n_full, n_range, n_empty;

	array_linked_list_engine_core #(.SLOTS(NODES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.item_value(item_value),
		.list_length(list_length),
		.last(last)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d beats still expected",
				cycle_count, pending_beats.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic list_beat_t make_beat(input logic [STATUS_W-1:0] st,
		input logic signed [VALUE_W-1:0] v, input int len, input logic lst);
		list_beat_t b;
		b.status      = st;
		b.item_value  = v;
		b.list_length = len[LEN_W-1:0];
		b.last        = lst;
		return b;
	endfunction

	function automatic void reset_list_model();
		for (int i = 1; i <= NODES; i++) begin
			node_val[i]  = '0;
			node_next[i] = (i < NODES) ? LEN_W'(i + 1) : '0;
		end
		list_head  = '0;
		free_head  = LEN_W'(1);
		list_count = 0;
	endfunction

	// Node that sits just ahead of one-based position pos (pos >= 2)
	function automatic logic [LEN_W-1:0] node_ahead_of(input int pos);
		logic [LEN_W-1:0] t;
		t = list_head;
		for (int j = 1; j + 1 < pos; j++)
			t = node_next[t];
		return t;
	endfunction

	// Apply one action to the shadow list and collect the beats it yields
	task automatic predict_list_action(input logic [ACTION_W-1:0] act,
		input logic [POS_W-1:0] pos_in, input logic signed [VALUE_W-1:0] val,
		output list_beat_t beats[$]);
		logic [LEN_W-1:0] k;
		logic [LEN_W-1:0] t;
		int pos;
		beats = {};
		pos = int'(pos_in);
		case (act)
			ACT_INSERT: begin
				n_insert++;
				if (list_count >= NODES || free_head == '0) begin
					beats.push_back(make_beat(ST_FULL, '0, list_count, 1'b1));
				end else if (pos < 1 || pos > list_count + 1) begin
					beats.push_back(make_beat(ST_RANGE, '0, list_count, 1'b1));
				end else begin
					k = free_head;
					free_head = node_next[k];
					node_val[k] = val;
					if (pos == 1) begin
						node_next[k] = list_head;
						list_head = k;
					end else begin
						t = node_ahead_of(pos);
						node_next[k] = node_next[t];
						node_next[t] = k;
					end
					list_count++;
					beats.push_back(make_beat(ST_OK, '0, list_count, 1'b1));
				end
			end
			ACT_DELETE: begin
				n_delete++;
				if (pos < 1 || pos > list_count) begin
					beats.push_back(make_beat(ST_RANGE, '0, list_count, 1'b1));
				end else begin
					if (pos == 1) begin
						k = list_head;
						list_head = node_next[k];
					end else begin
						t = node_ahead_of(pos);
						k = node_next[t];
						node_next[t] = node_next[k];
					end
					node_next[k] = free_head;
					free_head = k;
					list_count--;
					beats.push_back(make_beat(ST_OK, '0, list_count, 1'b1));
				end
			end
			ACT_DUMP: begin
				n_dump++;
				if (list_count == 0) begin
					beats.push_back(make_beat(ST_EMPTY, '0, 0, 1'b1));
				end else begin
					t = list_head;
					for (int n = 0; n < list_count; n++) begin
						beats.push_back(make_beat(ST_OK, node_val[t], list_count,
							n + 1 == list_count));
						t = node_next[t];
					end
				end
			end
			default: n_ignored++;
		endcase
	endtask

	// Present one beat after a gap, wait for it to be taken, then predict it
	task automatic drive_action(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
		input logic signed [VALUE_W-1:0] val, input int gap, input logic typed,
		input list_beat_t typed_beat);
		list_beat_t beats[$];
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		position <= pos;
		value    <= val;
		do @(posedge clk); while (!in_ready);
		predict_list_action(act, pos, val, beats);
		if (typed)
			pending_beats.push_back(typed_beat);
		else
			foreach (beats[i]) pending_beats.push_back(beats[i]);
		@(negedge clk);
	endtask

	function automatic void add_row(input logic [ACTION_W-1:0] act, input int pos,
		input logic signed [VALUE_W-1:0] val, input logic typed,
		input logic [STATUS_W-1:0] st, input int len);
		stim_row_t r;
		r.act   = act;
		r.pos   = POS_W'(pos);
		r.val   = val;
		r.typed = typed;
		r.beat  = make_beat(st, '0, len, 1'b1);
		directed_rows.push_back(r);
	endfunction

	// Idle gaps, with stretches of back-to-back beats
	function automatic int draw_gap(input int index);
		return (index % 50 < 12) ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Check every taken result beat against the oldest expectation
	always @(posedge clk) begin
		list_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_checked++;
			if (pending_beats.size() == 0) begin
				flag_mismatch("result beat count", beats_checked, beats_checked - 1);
			end else begin
				want = pending_beats.pop_front();
				if (status !== want.status)
					flag_mismatch("status", status, want.status);
				if (item_value !== want.item_value)
					flag_mismatch("item_value", item_value, want.item_value);
				if (list_length !== want.list_length)
					flag_mismatch("list_length", list_length, want.list_length);
				if (last !== want.last)
					flag_mismatch("last", last, want.last);
				if (want.status == ST_FULL) n_full++;
				if (want.status == ST_RANGE) n_range++;
				if (want.status == ST_EMPTY) n_empty++;
			end
		end
	end

	// Result side: stall at random, then hold ready until a beat is taken
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_gap(beats_out + 7);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			beats_out++;
			@(negedge clk);
		end
	end

	// Stimulus: reset, directed table, random grow and shrink phases, drain
	initial begin
		int sent;
		int roll;
		int pos;
		logic [ACTION_W-1:0] act;
		logic growing;
		list_beat_t no_beat;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = ACT_INSERT;
		position      = '0;
		value         = '0;
		error_count   = 0;
		beats_checked = 0;
		beats_out     = 0;
		cycle_count   = 0;
		n_insert = 0; n_delete = 0; n_dump = 0; n_ignored = 0;
		n_full = 0; n_range = 0; n_empty = 0;
		no_beat = '0;
		reset_list_model();

		// Empty list, bad positions, extremes of value and position, an unused code, dumps, deletes
		add_row(ACT_DUMP,   0,   32'sd0,        1'b1, ST_EMPTY, 0);
		add_row(ACT_DELETE, 1,   32'sd0,        1'b1, ST_RANGE, 0);
		add_row(ACT_INSERT, 0,   32'sd5,        1'b1, ST_RANGE, 0);
		add_row(ACT_INSERT, 2,   32'sd6,        1'b1, ST_RANGE, 0);
		add_row(ACT_INSERT, 1,   32'h7FFFFFFF,  1'b1, ST_OK,    1);
		add_row(ACT_INSERT, 1,   32'h80000000,  1'b1, ST_OK,    2);
		add_row(ACT_INSERT, 3,   -32'sd1,       1'b1, ST_OK,    3);
		add_row(ACT_INSERT, 255, 32'sd7,        1'b1, ST_RANGE, 3);
		add_row(ACT_UNUSED, 255, 32'hFFFFFFFF,  1'b0, ST_OK,    0);
		add_row(ACT_DUMP,   255, 32'sd0,        1'b0, ST_OK,    0);
		add_row(ACT_INSERT, 2,   32'sd0,        1'b1, ST_OK,    4);
		add_row(ACT_INSERT, 3,   32'h5555AAAA,  1'b0, ST_OK,    0);
		add_row(ACT_DUMP,   0,   32'sd0,        1'b0, ST_OK,    0);
		add_row(ACT_DELETE, 0,   32'sd0,        1'b1, ST_RANGE, 5);
		add_row(ACT_DELETE, 6,   32'sd0,        1'b1, ST_RANGE, 5);
		add_row(ACT_DELETE, 255, 32'sd0,        1'b1, ST_RANGE, 5);
		add_row(ACT_DELETE, 5,   32'sd0,        1'b0, ST_OK,    0);
		add_row(ACT_DELETE, 2,   32'sd0,        1'b0, ST_OK,    0);
		add_row(ACT_DELETE, 1,   32'sd0,        1'b0, ST_OK,    0);
		add_row(ACT_INSERT, 1,   32'hAAAA5555,  1'b0, ST_OK,    0);
		add_row(ACT_DUMP,   0,   32'sd0,        1'b0, ST_OK,    0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		sent = 0;
		foreach (directed_rows[i]) begin
			drive_action(directed_rows[i].act, directed_rows[i].pos, directed_rows[i].val,
				draw_gap(sent), directed_rows[i].typed, directed_rows[i].beat);
			sent++;
		end

		// Grow toward a full store, linger there, then shrink to empty and repeat
		growing = 1'b1;
		for (int n = 0; n < RANDOM_ACTIONS; ) begin
			if (growing && list_count == NODES && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (!growing && list_count == 0 && $urandom_range(0, 2) == 0)
				growing = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 4)
				act = ACT_UNUSED;
			else if (roll < 14)
				act = ACT_DUMP;
			else if (roll < 84)
				act = growing ? ACT_INSERT : ACT_DELETE;
			else
				act = growing ? ACT_DELETE : ACT_INSERT;
			if ($urandom_range(0, 99) < 14)
				pos = $urandom_range(0, 255);
			else if (act == ACT_INSERT)
				pos = $urandom_range(1, list_count + 1);
			else if (list_count > 0)
				pos = $urandom_range(1, list_count);
			else
				pos = $urandom_range(0, 255);
			drive_action(act, POS_W'(pos), $urandom, draw_gap(sent), 1'b0, no_beat);
			sent++;
			if (act != ACT_UNUSED)
				n++;
		end
		in_valid <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d actions: %0d inserts, %0d deletes, %0d dumps, %0d unused codes",
			sent, n_insert, n_delete, n_dump, n_ignored);
		$display("Checked %0d result beats: %0d store full, %0d bad position, %0d empty dump",
			beats_checked, n_full, n_range, n_empty);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/alle_pkg.sv
src/alle_link_mem.sv
src/alle_value_mem.sv
src/alle_ctrl.sv
src/array_linked_list_engine_core.sv
bench/array_linked_list_engine_core_test.sv
